### hdl/sci_pkg.sv
`timescale 1ns / 1ps
package sci_pkg;

  localparam int RAW_W   = 16;
  localparam int REAL_W  = 24;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int DEPTH   = 64;
  localparam int FRAC_W  = 8;
  localparam int NUM_W   = RAW_W + 1;
  localparam int DY_W    = REAL_W + 1;
  localparam int PROD_W  = RAW_W + DY_W;
  localparam int VAL_W   = PROD_W + 2;
  localparam int DCNT_W  = $clog2(PROD_W);

  localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'((64'sd1 <<< (REAL_W - 1)) - 64'sd1);
  localparam logic signed [VAL_W-1:0] VAL_MIN = VAL_W'(-(64'sd1 <<< (REAL_W - 1)));

  // Work classes decided when a request is accepted.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PASS,
    OP_SINGLE,
    OP_SEARCH
  } op_t;

  typedef enum logic [2:0] {
    KIND_INTERP = 3'd0,
    KIND_LOW    = 3'd1,
    KIND_HIGH   = 3'd2,
    KIND_PASS   = 3'd3,
    KIND_SINGLE = 3'd4,
    KIND_LOAD   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RDL,
    ST_SCAN,
    ST_FA,
    ST_FB,
    ST_FC,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_SAT
  } st_t;

  // One request as it travels from the front queue to the back end.
  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic [RAW_W-1:0]        raw;
    logic signed [REAL_W-1:0] real_v;
  } item_t;

endpackage

### hdl/sci_front.sv
`timescale 1ns / 1ps
module sci_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        cmd,
  input  logic [sci_pkg::IDX_W-1:0]   idx,
  input  logic [sci_pkg::RAW_W-1:0]   entry_raw,
  input  logic signed [sci_pkg::REAL_W-1:0] entry_real,
  input  logic [sci_pkg::RAW_W-1:0]   sample_raw,
  input  logic [sci_pkg::CNT_W-1:0]   n,
  output logic                        deq_valid,
  input  logic                        deq_ready,
  output sci_pkg::item_t              deq_item
);
  import sci_pkg::*;

  item_t      q_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic       enq, deq;
  item_t      new_item;

  // Classify the request by command and table size.
  always_comb begin
    new_item.idx    = idx;
    new_item.real_v = entry_real;
    if (cmd == 1'b0) begin
      new_item.op  = OP_LOAD;
      new_item.raw = entry_raw;
    end else begin
      new_item.raw = sample_raw;
      if (n == '0) begin
        new_item.op = OP_PASS;
      end else if (n == CNT_W'(1)) begin
        new_item.op = OP_SINGLE;
      end else begin
        new_item.op = OP_SEARCH;
      end
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign deq_valid = (cnt_r != 2'd0);
  assign deq_item  = q_r[rd_ptr_r];
  assign enq       = push && !full;
  assign deq       = deq_valid && deq_ready;

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (enq) wr_ptr_r <= !wr_ptr_r;
      if (deq) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

### hdl/sci_back.sv
`timescale 1ns / 1ps
module sci_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sci_pkg::item_t              in_item,
  input  logic [sci_pkg::CNT_W-1:0]   n,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [sci_pkg::REAL_W-1:0] res_value,
  output logic [2:0]                  res_kind,
  output logic                        res_sat
);
  import sci_pkg::*;

  logic [RAW_W-1:0]         raw_mem  [DEPTH];
  logic signed [REAL_W-1:0] real_mem [DEPTH];
  logic [RAW_W-1:0]         rd_raw_r;
  logic signed [REAL_W-1:0] rd_real_r;
  logic [IDX_W-1:0]         mem_addr;
  logic                     mem_we;

  st_t                      st_r, st_nxt;
  item_t                    item_r, item_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt, a_r, a_nxt, last;
  logic [RAW_W-1:0]         prev_r, prev_nxt, raw0_r, raw0_nxt;
  logic [RAW_W-1:0]         x0_r, x0_nxt, x1_r, x1_nxt;
  logic signed [REAL_W-1:0] y0_r, y0_nxt, y1_r, y1_nxt;
  logic                     up_r, up_nxt, use_last_r, use_last_nxt, neg_r, neg_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [RAW_W-1:0]         un_r, un_nxt, ud_r, ud_nxt;
  logic [DY_W-1:0]          uy_r, uy_nxt;
  logic [RAW_W-1:0]         rem_r, rem_nxt;
  logic [PROD_W-1:0]        sh_r, sh_nxt;
  logic [DCNT_W-1:0]        dcnt_r, dcnt_nxt;
  logic signed [VAL_W-1:0]  val_r, val_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [REAL_W-1:0] out_value_r, out_value_nxt;
  kind_t                    out_kind_r, out_kind_nxt;
  logic                     out_sat_r, out_sat_nxt;

  logic                     out_free, hit;
  logic [NUM_W:0]           trial;
  logic signed [NUM_W-1:0]  num, den;
  logic signed [DY_W-1:0]   dy;
  logic signed [VAL_W-1:0]  y0_ext, q_ext;

  assign last     = IDX_W'(n - CNT_W'(1));
  assign out_free = !out_valid_r || pop;
  assign in_ready = (st_r == ST_IDLE);
  assign mem_we   = in_ready && in_valid && (in_item.op == OP_LOAD);

  // Table memories with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      raw_mem[in_item.idx]  <= in_item.raw;
      real_mem[in_item.idx] <= in_item.real_v;
    end
    rd_raw_r  <= raw_mem[mem_addr];
    rd_real_r <= real_mem[mem_addr];
  end

  // Segment test on the pair now at hand.
  always_comb begin
    if (up_r) begin
      hit = (item_r.raw >= prev_r) && (item_r.raw <= rd_raw_r);
    end else begin
      hit = (item_r.raw <= prev_r) && (item_r.raw >= rd_raw_r);
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.op == OP_LOAD || in_item.op == OP_PASS) begin
            st_nxt = ST_SAT;
          end else begin
            st_nxt = ST_RD0;
          end
        end
      end
      ST_RD0:   st_nxt = (item_r.op == OP_SINGLE) ? ST_SAT : ST_RDL;
      ST_RDL:   st_nxt = ST_SCAN;
      ST_SCAN:  if (hit || idx_r == last) st_nxt = ST_FA;
      ST_FA:    st_nxt = ST_FB;
      ST_FB:    st_nxt = ST_FC;
      ST_FC:    st_nxt = ST_SETUP;
      ST_SETUP: st_nxt = (x0_r == x1_r) ? ST_SAT : ST_MUL;
      ST_MUL:   st_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == DCNT_W'(PROD_W - 1)) st_nxt = ST_SUM;
      ST_SUM:   st_nxt = ST_SAT;
      ST_SAT:   if (out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory address per state.
  always_comb begin
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    a_nxt         = a_r;
    prev_nxt      = prev_r;
    raw0_nxt      = raw0_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    up_nxt        = up_r;
    use_last_nxt  = use_last_r;
    neg_nxt       = neg_r;
    kind_nxt      = kind_r;
    un_nxt        = un_r;
    ud_nxt        = ud_r;
    uy_nxt        = uy_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    dcnt_nxt      = dcnt_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !pop;
    out_value_nxt = out_value_r;
    out_kind_nxt  = out_kind_r;
    out_sat_nxt   = out_sat_r;
    mem_addr      = '0;
    num           = '0;
    den           = '0;
    dy            = '0;
    trial         = '0;
    y0_ext        = VAL_W'(y0_r);
    q_ext         = $signed({2'b00, sh_r});
    case (st_r)
      ST_IDLE: begin
        item_nxt = in_item;
        case (in_item.op)
          OP_LOAD: begin
            val_nxt  = '0;
            kind_nxt = KIND_LOAD;
          end
          OP_PASS: begin
            val_nxt  = $signed({{(VAL_W - RAW_W - FRAC_W){1'b0}}, in_item.raw, {FRAC_W{1'b0}}});
            kind_nxt = KIND_PASS;
          end
          default: kind_nxt = KIND_SINGLE;
        endcase
      end
      ST_RD0: begin
        val_nxt  = VAL_W'(rd_real_r);
        raw0_nxt = rd_raw_r;
        mem_addr = last;
      end
      ST_RDL: begin
        up_nxt   = (raw0_r <= rd_raw_r);
        prev_nxt = raw0_r;
        idx_nxt  = IDX_W'(1);
        mem_addr = IDX_W'(1);
      end
      ST_SCAN: begin
        if (hit) begin
          a_nxt        = idx_r - IDX_W'(1);
          kind_nxt     = KIND_INTERP;
          use_last_nxt = 1'b0;
        end else if (idx_r == last) begin
          if (item_r.raw < raw0_r) begin
            a_nxt        = '0;
            kind_nxt     = KIND_LOW;
            use_last_nxt = 1'b0;
          end else begin
            a_nxt        = last - IDX_W'(1);
            kind_nxt     = KIND_HIGH;
            use_last_nxt = 1'b1;
          end
        end else begin
          prev_nxt = rd_raw_r;
          idx_nxt  = idx_r + IDX_W'(1);
          mem_addr = idx_r + IDX_W'(1);
        end
      end
      ST_FA: mem_addr = a_r;
      ST_FB: begin
        x0_nxt   = rd_raw_r;
        y0_nxt   = rd_real_r;
        mem_addr = a_r + IDX_W'(1);
      end
      ST_FC: begin
        x1_nxt = rd_raw_r;
        y1_nxt = rd_real_r;
      end
      // Signs and magnitudes of the three differences.
      ST_SETUP: begin
        num = $signed({1'b0, item_r.raw}) - $signed({1'b0, x0_r});
        den = $signed({1'b0, x1_r}) - $signed({1'b0, x0_r});
        dy  = DY_W'(y1_r) - DY_W'(y0_r);
        un_nxt  = num[NUM_W-1] ? RAW_W'(-num) : RAW_W'(num);
        ud_nxt  = den[NUM_W-1] ? RAW_W'(-den) : RAW_W'(den);
        uy_nxt  = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);
        neg_nxt = num[NUM_W-1] ^ den[NUM_W-1] ^ dy[DY_W-1];
        val_nxt = use_last_r ? VAL_W'(y1_r) : VAL_W'(y0_r);
      end
      ST_MUL: begin
        sh_nxt   = PROD_W'(un_r) * PROD_W'(uy_r);
        rem_nxt  = '0;
        dcnt_nxt = '0;
      end
      // Restoring division, one quotient bit per cycle.
      ST_DIV: begin
        trial = {1'b0, rem_r, sh_r[PROD_W-1]};
        if (trial >= {2'b00, ud_r}) begin
          rem_nxt = RAW_W'(trial - {2'b00, ud_r});
          sh_nxt  = {sh_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt = RAW_W'(trial);
          sh_nxt  = {sh_r[PROD_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCNT_W'(1);
      end
      ST_SUM: val_nxt = neg_r ? (y0_ext - q_ext) : (y0_ext + q_ext);
      // Clip to the output range and hand over to the result register.
      ST_SAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          if (val_r > VAL_MAX) begin
            out_value_nxt = REAL_W'(VAL_MAX);
            out_sat_nxt   = 1'b1;
          end else if (val_r < VAL_MIN) begin
            out_value_nxt = REAL_W'(VAL_MIN);
            out_sat_nxt   = 1'b1;
          end else begin
            out_value_nxt = REAL_W'(val_r);
            out_sat_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    idx_r       <= idx_nxt;
    a_r         <= a_nxt;
    prev_r      <= prev_nxt;
    raw0_r      <= raw0_nxt;
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    y0_r        <= y0_nxt;
    y1_r        <= y1_nxt;
    up_r        <= up_nxt;
    use_last_r  <= use_last_nxt;
    neg_r       <= neg_nxt;
    kind_r      <= kind_nxt;
    un_r        <= un_nxt;
    ud_r        <= ud_nxt;
    uy_r        <= uy_nxt;
    rem_r       <= rem_nxt;
    sh_r        <= sh_nxt;
    dcnt_r      <= dcnt_nxt;
    val_r       <= val_nxt;
    out_value_r <= out_value_nxt;
    out_kind_r  <= out_kind_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign empty     = !out_valid_r;
  assign res_value = out_value_r;
  assign res_kind  = out_kind_r;
  assign res_sat   = out_sat_r;

endmodule

### hdl/sensor_calibration_interpolator_top.sv
`timescale 1ns / 1ps
// Channel   Ports                                  Request accepted when
// input     push/full, in_*                        push && !full
// result    empty/pop, out_*                       pop && !empty
// config    psel/penable/pwrite/paddr/pwdata/...   psel && penable && pwrite
//
// A load or a passthrough conversion goes from acceptance straight to the result
// stage; a single-entry conversion first reads entry 0. A search conversion reads
// one table entry per cycle through the single memory read port, then runs a
// restoring divider for a 41-bit quotient unless the segment has zero width.
// Synchronous active-low reset clears control state; the tables are not cleared.
// A two-entry queue lets requests arrive while a conversion is running.
module sensor_calibration_interpolator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_command,
  input  logic [sci_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [sci_pkg::RAW_W-1:0]   in_entry_raw,
  input  logic signed [sci_pkg::REAL_W-1:0] in_entry_real,
  input  logic [sci_pkg::RAW_W-1:0]   in_sample_raw,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [sci_pkg::REAL_W-1:0] out_real_value,
  output logic [2:0]                  out_result_kind,
  output logic                        out_saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sci_pkg::*;

  logic [CNT_W-1:0] entries_used_r;
  logic [CNT_W-1:0] n;
  logic             deq_valid, bk_ready;
  item_t            deq_item;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - CNT_W){1'b0}}, entries_used_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      entries_used_r <= pwdata[CNT_W-1:0];
    end
  end

  // Counts above the table depth act as a full table.
  assign n = (entries_used_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : entries_used_r;

  sci_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .cmd        (in_command),
    .idx        (in_entry_index),
    .entry_raw  (in_entry_raw),
    .entry_real (in_entry_real),
    .sample_raw (in_sample_raw),
    .n          (n),
    .deq_valid  (deq_valid),
    .deq_ready  (bk_ready),
    .deq_item   (deq_item)
  );

  sci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (deq_valid),
    .in_ready  (bk_ready),
    .in_item   (deq_item),
    .n         (n),
    .empty     (empty),
    .pop       (pop),
    .res_value (out_real_value),
    .res_kind  (out_result_kind),
    .res_sat   (out_saturated)
  );

`ifndef SYNTHESIS
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_saturated) |->
      (out_real_value == REAL_W'(VAL_MAX) || out_real_value == REAL_W'(VAL_MIN)))
    else $error("saturated result not at a range limit");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == KIND_LOAD) |-> (out_real_value == '0 && !out_saturated))
    else $error("load result carries a value");

  a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (deq_valid && bk_ready) |=> !bk_ready)
    else $error("back end took a request without going busy");
`endif

endmodule

### verif/sensor_calibration_interpolator_checker.sv
`timescale 1ns / 1ps
module sensor_calibration_interpolator_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic                                full,
  input  logic                                in_command,
  input  logic [sci_pkg::IDX_W-1:0]           in_entry_index,
  input  logic [sci_pkg::RAW_W-1:0]           in_entry_raw,
  input  logic signed [sci_pkg::REAL_W-1:0]   in_entry_real,
  input  logic [sci_pkg::RAW_W-1:0]           in_sample_raw,
  input  logic                                empty,
  input  logic                                pop,
  input  logic signed [sci_pkg::REAL_W-1:0]   out_real_value,
  input  logic [2:0]                          out_result_kind,
  input  logic                                out_saturated,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  input  logic                                pready,
  output int                                  fail_count,
  output int                                  results_pending
);
  import sci_pkg::*;

  localparam logic [0:0] CMD_CONVERT = 1'b1;
  localparam int         REG_ENTRIES_USED = 0;

  typedef struct {
    logic signed [REAL_W-1:0] value;
    kind_t                    kind;
    logic                     sat;
  } calib_result_t;

  // Shadow copy of the calibration pairs and the entry count.
  logic [RAW_W-1:0]         raw_points [DEPTH];
  logic signed [REAL_W-1:0] real_points [DEPTH];
  logic [CNT_W-1:0]         entries_used;
  calib_result_t            expected_results [$];

  assign results_pending = expected_results.size();

  // Straight line through (x0,y0) and (x1,y1) at s, offset from y0 truncated toward zero.
  function automatic longint line_value(longint s, longint x0, longint x1,
                                        longint y0, longint y1);
    longint num, den, dy, q;
    bit     neg;
    num = s - x0;
    den = x1 - x0;
    dy  = y1 - y0;
    neg = (num < 0) ^ (den < 0) ^ (dy < 0);
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    if (dy < 0) dy = -dy;
    q = (num * dy) / den;
    return neg ? y0 - q : y0 + q;
  endfunction

  function automatic calib_result_t convert_sample(logic [RAW_W-1:0] sample);
    calib_result_t r;
    int            n, a, b, seg;
    bit            up;
    longint        s, v;
    s   = longint'(sample);
    n   = (entries_used > DEPTH) ? DEPTH : int'(entries_used);
    seg = -1;
    a   = 0;
    b   = 1;
    if (n == 0) begin
      v = s * 256;
      r.kind = KIND_PASS;
    end else if (n == 1) begin
      v = longint'(real_points[0]);
      r.kind = KIND_SINGLE;
    end else begin
      up = raw_points[0] <= raw_points[n-1];
      for (int i = 0; i + 1 < n; i++) begin
        if (seg < 0) begin
          if (up ? (s >= raw_points[i] && s <= raw_points[i+1])
                 : (s <= raw_points[i] && s >= raw_points[i+1]))
            seg = i;
        end
      end
      if (seg >= 0) begin
        a = seg;
        b = seg + 1;
        r.kind = KIND_INTERP;
      end else if (s < longint'(raw_points[0])) begin
        r.kind = KIND_LOW;
      end else begin
        a = n - 2;
        b = n - 1;
        r.kind = KIND_HIGH;
      end
      // A zero-width segment returns one of its end values.
      if (raw_points[a] == raw_points[b])
        v = (r.kind == KIND_HIGH) ? longint'(real_points[b]) : longint'(real_points[a]);
      else
        v = line_value(s, raw_points[a], raw_points[b],
                       longint'(real_points[a]), longint'(real_points[b]));
    end
    r.sat = 1'b0;
    if (v > longint'(VAL_MAX)) begin
      v = longint'(VAL_MAX);
      r.sat = 1'b1;
    end else if (v < longint'(VAL_MIN)) begin
      v = longint'(VAL_MIN);
      r.sat = 1'b1;
    end
    r.value = v[REAL_W-1:0];
    return r;
  endfunction

  // Track register writes, predict accepted requests and check results.
  always @(posedge clk) begin
    calib_result_t exp_r;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      entries_used <= '0;
      fail_count   <= 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && (paddr >> 2) == REG_ENTRIES_USED)
        entries_used <= pwdata[CNT_W-1:0];
      if (push && !full) begin
        if (in_command == CMD_CONVERT) begin
          exp_r = convert_sample(in_sample_raw);
        end else begin
          raw_points[in_entry_index]  <= in_entry_raw;
          real_points[in_entry_index] <= in_entry_real;
          exp_r.value = '0;
          exp_r.kind  = KIND_LOAD;
          exp_r.sat   = 1'b0;
        end
        expected_results.push_back(exp_r);
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: real_value %0d", out_real_value);
          errs = errs + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_real_value !== exp_r.value) begin
            $error("real_value: expected %0d, actual %0d", exp_r.value, out_real_value);
            errs = errs + 1;
          end
          if (out_result_kind !== exp_r.kind) begin
            $error("result_kind: expected %0d, actual %0d", exp_r.kind, out_result_kind);
            errs = errs + 1;
          end
          if (out_saturated !== exp_r.sat) begin
            $error("saturated: expected %0d, actual %0d", exp_r.sat, out_saturated);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0)
        fail_count <= fail_count + errs;
    end
  end

endmodule

### verif/sensor_calibration_interpolator_top_tb.sv
`timescale 1ns / 1ps
module sensor_calibration_interpolator_top_tb;
  import sci_pkg::*;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;
  localparam logic [2:0] ADDR_ENTRIES_USED = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
  localparam int ITEM_TARGET  = 1550;
  localparam int STALL_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0, full;
  logic in_command = 1'b0;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic [RAW_W-1:0] in_entry_raw = '0;
  logic signed [REAL_W-1:0] in_entry_real = '0;
  logic [RAW_W-1:0] in_sample_raw = '0;
  logic empty, pop = 1'b0;
  logic signed [REAL_W-1:0] out_real_value;
  logic [2:0] out_result_kind;
  logic out_saturated;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, results_pending;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  logic [RAW_W-1:0] raw_shadow [DEPTH];

  always #4 clk = ~clk;

  sensor_calibration_interpolator_top dut (.*);

  sensor_calibration_interpolator_checker checker_i (.*);

  // Result side stalls at random outside the calm stretch.
  always @(posedge clk) begin
    pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(logic cmd, logic [IDX_W-1:0] idx, logic [RAW_W-1:0] raw,
                              logic signed [REAL_W-1:0] real_v, logic [RAW_W-1:0] sample);
    while (!calm && $urandom_range(0, 99) < 11) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= idx;
    in_entry_raw   <= raw;
    in_entry_real  <= real_v;
    in_sample_raw  <= sample;
    do @(posedge clk); while (full);
    if (cmd == CMD_LOAD) raw_shadow[idx] = raw;
    items_sent++;
  endtask

  task automatic load_pair(int idx, logic [RAW_W-1:0] raw, logic signed [REAL_W-1:0] real_v);
    send_request(CMD_LOAD, IDX_W'(idx), raw, real_v, RAW_W'($urandom));
  endtask

  task automatic convert(logic [RAW_W-1:0] sample);
    send_request(CMD_CONVERT, IDX_W'($urandom), RAW_W'($urandom),
                 REAL_W'($urandom), sample);
  endtask

  // Let the block drain completely before touching its register.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrite the first m pairs as a rising, falling or unordered curve.
  task automatic build_curve(int m);
    int style, raw_pos, step;
    style   = $urandom_range(0, 2);
    raw_pos = (style == 1) ? $urandom_range(40000, 65535) : $urandom_range(0, 20000);
    for (int i = 0; i < m; i++) begin
      step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3000);
      if (style == 2) raw_pos = $urandom_range(0, 65535);
      load_pair(i, RAW_W'(raw_pos), REAL_W'($urandom));
      if (style == 0) raw_pos = (raw_pos + step > 65535) ? 65535 : raw_pos + step;
      if (style == 1) raw_pos = (raw_pos - step < 0) ? 0 : raw_pos - step;
    end
  endtask

  initial begin
    int n, m, burst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: passthrough, with saturation at the top end.
    write_reg(ADDR_ENTRIES_USED, 32'd0);
    convert(16'd0);
    convert(16'd1);
    convert(16'hFFFF);
    write_reg(ADDR_UNMAPPED, 32'd5);
    convert(16'd1234);

    // Fill every pair so no conversion reads an unwritten entry.
    for (int i = 0; i < DEPTH; i++)
      load_pair(i, (i == DEPTH - 1) ? 16'hFFFF : RAW_W'(500 + i * 1000),
                (i == 0) ? REAL_W'(-24'sd8388608) :
                (i == DEPTH - 1) ? REAL_W'(24'sd8388607) : REAL_W'(i * 4096));

    write_reg(ADDR_ENTRIES_USED, 32'd1);
    convert(16'd7);
    write_reg(ADDR_ENTRIES_USED, 32'd64);
    convert(16'd0);
    convert(16'd30000);
    convert(16'd62500);
    convert(16'hFFFF);
    write_reg(ADDR_ENTRIES_USED, 32'd127);
    convert(16'd33333);
    write_reg(ADDR_ENTRIES_USED, 32'd2);
    convert(16'hFFFF);
    convert(16'd0);

    // Zero-width first segment.
    load_pair(1, 16'd500, 24'sd1000);
    convert(16'd500);
    convert(16'd100);
    convert(16'd600);

    // Random phases, each with its own count and, usually, a newly built curve.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: n = 0;
        1: n = 1;
        2: n = $urandom_range(2, 3);
        3: n = 64;
        4: n = $urandom_range(65, 127);
        default: n = $urandom_range(2, 16);
      endcase
      write_reg(ADDR_ENTRIES_USED, 32'(n));
      m = (n > DEPTH) ? DEPTH : n;
      if ($urandom_range(0, 9) < 7) build_curve(m);
      burst = $urandom_range(20, 60);
      for (int k = 0; k < burst; k++) begin
        calm = (items_sent >= 700 && items_sent < 900);
        if ($urandom_range(0, 99) < 15)
          load_pair($urandom_range(0, DEPTH - 1), RAW_W'($urandom), REAL_W'($urandom));
        else if (m > 0 && $urandom_range(0, 1) == 0)
          convert(RAW_W'(int'(raw_shadow[$urandom_range(0, m - 1)]) +
                         $urandom_range(0, 6) - 3));
        else
          convert(RAW_W'($urandom));
        // At random, hold the sender mid-phase until the block has caught up.
        if (k == burst / 2 && $urandom_range(0, 3) == 0) wait_drained();
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
